// File: hdl/sbpe_pkg.sv
// Shared types and constants for the servo bus packet engine.
// No dependencies; every other file in the block imports this package.
package sbpe_pkg;

	// Frame and reply constants.
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] LEN_EXTRA  = 8'h02;
	localparam logic [3:0] HDR_LEN    = 4'd5;

	// Clamp limits for the parameter count and the expected reply data count.
	localparam logic [2:0] MAX_PARAMS     = 3'd6;
	localparam logic [2:0] MAX_REPLY_DATA = 3'd4;
	localparam int         PARAM_SLOTS    = 6;

	// Command codes carried on the command channel.
	localparam logic [1:0] FUNC_REQUEST = 2'd0;
	localparam logic [1:0] FUNC_RECEIVE = 2'd1;
	localparam logic [1:0] FUNC_ABORT   = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_REPLY   = 2'd1;
	localparam logic [1:0] KIND_ABORTED = 2'd2;

	// Error flag bits above the servo error byte.
	localparam logic [11:0] ERR_HEADER   = 12'h100;
	localparam logic [11:0] ERR_ID       = 12'h200;
	localparam logic [11:0] ERR_LENGTH   = 12'h400;
	localparam logic [11:0] ERR_CHECKSUM = 12'h800;

	// Command beat as it arrives on the port.
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  servo_id;
		logic [7:0]  instruction;
		logic [2:0]  param_count;
		logic [47:0] param_bytes;
		logic [2:0]  reply_data_count;
		logic [7:0]  rx_byte;
	} cmd_beat_t;

	// Result beat as it leaves on the port.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [15:0] reply_value;
		logic [11:0] error_flags;
	} res_beat_t;

	// Classified command held in the queue between front and back.
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  servo_id;
		logic [7:0]  instruction;
		logic [2:0]  pcount;
		logic [47:0] params;
		logic [2:0]  rdc;
		logic [7:0]  len;
		logic [7:0]  checksum;
		logic [7:0]  rx_byte;
	} op_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic head_valid;
		logic push_ready;
	} queue_status_t;

endpackage

// File: hdl/sbpe_front.sv
// Front end: accepts command beats, drops unknown codes, clamps counts and
// precomputes the frame length and checksum. Depends on sbpe_pkg.
module sbpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  sbpe_pkg::cmd_beat_t cmd_beat,
	output logic              push_valid,
	input  logic              push_ready,
	output sbpe_pkg::op_t     push_op
);
	import sbpe_pkg::*;

	logic       valid_s1;
	op_t        op_s1;
	op_t        op_d;
	logic [2:0] pc;
	logic [2:0] rdc;
	logic [7:0] len;
	logic [7:0] sum;
	logic       load;

	// Clamp the counts and sum the frame bytes covered by the checksum.
	always_comb begin
		pc  = (cmd_beat.param_count > MAX_PARAMS) ? MAX_PARAMS : cmd_beat.param_count;
		rdc = (cmd_beat.reply_data_count > MAX_REPLY_DATA) ? MAX_REPLY_DATA
			: cmd_beat.reply_data_count;
		len = {5'b0, pc} + LEN_EXTRA;
		sum = cmd_beat.servo_id + len + cmd_beat.instruction;
		for (int i = 0; i < PARAM_SLOTS; i++) begin
			if (3'(i) < pc) begin
				sum = sum + cmd_beat.param_bytes[8*i +: 8];
			end
		end
		op_d.func        = cmd_beat.func;
		op_d.servo_id    = cmd_beat.servo_id;
		op_d.instruction = cmd_beat.instruction;
		op_d.pcount      = pc;
		op_d.params      = cmd_beat.param_bytes;
		op_d.rdc         = rdc;
		op_d.len         = len;
		op_d.checksum    = ~sum;
		op_d.rx_byte     = cmd_beat.rx_byte;
	end

	// The stage register moves whenever it is empty or the queue takes its beat.
	assign load      = !valid_s1 || push_ready;
	assign cmd_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= cmd_valid && (cmd_beat.func == FUNC_REQUEST
				|| cmd_beat.func == FUNC_RECEIVE || cmd_beat.func == FUNC_ABORT);
		end
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			op_s1 <= op_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_op    = op_s1;

endmodule

// File: hdl/sbpe_queue.sv
// Short first-in first-out queue of classified commands between front and back.
// Depends on sbpe_pkg.
module sbpe_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	input  sbpe_pkg::op_t           push_op,
	input  logic                    pop,
	output sbpe_pkg::queue_status_t status,
	output sbpe_pkg::op_t           head_op
);
	import sbpe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign status.push_ready = (count_q != CW'(DEPTH));
	assign status.head_valid = (count_q != '0);
	assign do_push = push_valid && status.push_ready;
	assign do_pop  = pop && status.head_valid;
	assign head_op = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/sbpe_back.sv
// Back end: serialises request frames byte by byte, runs the reply parser and
// drives the registered result beat. Depends on sbpe_pkg.
module sbpe_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sbpe_pkg::queue_status_t status,
	input  sbpe_pkg::op_t           head_op,
	output logic                    pop,
	output logic                    res_valid,
	input  logic                    res_stall,
	output sbpe_pkg::res_beat_t     res_beat
);
	import sbpe_pkg::*;

	logic        res_valid_q;
	res_beat_t   res_q;
	logic [3:0]  pos_q;
	logic        pending_q;
	logic [7:0]  expected_id_q;
	logic [2:0]  expected_data_q;
	logic [3:0]  byte_index_q;
	logic [7:0]  header_q [5];
	logic [7:0]  data_sum_q;
	logic [15:0] data_lh_q;
	logic [11:0] error_q;

	logic        adv;
	logic        emit;
	logic        frame_last;
	logic [7:0]  frame_byte;
	logic [2:0]  param_idx;
	logic        in_header;
	logic        in_data;
	logic [3:0]  data_idx;
	logic [7:0]  n_len;
	logic [7:0]  chk;
	logic [11:0] err_new;
	logic [15:0] value;
	res_beat_t   res_d;

	assign adv = status.head_valid && (!res_valid_q || !res_stall);

	// Frame byte selection by position within the frame.
	always_comb begin
		param_idx  = 3'(pos_q - HDR_LEN);
		frame_last = (pos_q == ({1'b0, head_op.pcount} + HDR_LEN));
		frame_byte = 8'h00;
		if (frame_last) begin
			frame_byte = head_op.checksum;
		end else begin
			case (pos_q)
				4'd0, 4'd1: frame_byte = START_BYTE;
				4'd2:       frame_byte = head_op.servo_id;
				4'd3:       frame_byte = head_op.len;
				4'd4:       frame_byte = head_op.instruction;
				default: begin
					case (param_idx)
						3'd0:    frame_byte = head_op.params[7:0];
						3'd1:    frame_byte = head_op.params[15:8];
						3'd2:    frame_byte = head_op.params[23:16];
						3'd3:    frame_byte = head_op.params[31:24];
						3'd4:    frame_byte = head_op.params[39:32];
						3'd5:    frame_byte = head_op.params[47:40];
						default: frame_byte = 8'h00;
					endcase
				end
			endcase
		end
	end

	// Reply parser: header capture, data capture and final check.
	always_comb begin
		in_header = (byte_index_q < HDR_LEN);
		in_data   = (byte_index_q < ({1'b0, expected_data_q} + HDR_LEN));
		data_idx  = byte_index_q - HDR_LEN;
		err_new   = error_q | {4'b0, header_q[4]};
		if (header_q[0] != START_BYTE || header_q[1] != START_BYTE) begin
			err_new = err_new | ERR_HEADER;
		end
		if (header_q[2] != expected_id_q) begin
			err_new = err_new | ERR_ID;
		end
		n_len = {5'b0, expected_data_q};
		if (header_q[3] != ({5'b0, expected_data_q} + LEN_EXTRA)) begin
			n_len   = header_q[3] - LEN_EXTRA;
			err_new = err_new | ERR_LENGTH;
		end
		chk = ~(header_q[2] + header_q[3] + header_q[4] + data_sum_q);
		if (head_op.rx_byte != chk) begin
			err_new = err_new | ERR_CHECKSUM;
		end
		if (n_len == 8'd1) begin
			value = {8'h00, data_lh_q[7:0]};
		end else if (n_len == 8'd2) begin
			value = data_lh_q;
		end else begin
			value = 16'h0000;
		end
	end

	// Decide what the head command produces this cycle.
	always_comb begin
		res_d = '0;
		emit  = 1'b0;
		pop   = 1'b0;
		unique case (head_op.func)
			FUNC_REQUEST: begin
				emit          = 1'b1;
				pop           = adv && frame_last;
				res_d.kind    = KIND_TX;
				res_d.tx_byte = frame_byte;
				res_d.last    = frame_last;
			end
			FUNC_RECEIVE: begin
				pop = adv;
				if (pending_q && !in_header && !in_data) begin
					emit              = 1'b1;
					res_d.kind        = KIND_REPLY;
					res_d.reply_value = value;
					res_d.error_flags = err_new;
				end
			end
			FUNC_ABORT: begin
				pop = adv;
				if (pending_q) begin
					emit              = 1'b1;
					res_d.kind        = KIND_ABORTED;
					res_d.error_flags = error_q;
				end
			end
			default: begin
				pop = adv;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q <= status.head_valid && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res_d;
		end
	end

	// Header bytes of the reply in progress.
	always_ff @(posedge clk) begin
		if (adv && head_op.func == FUNC_RECEIVE && pending_q && in_header) begin
			header_q[byte_index_q[2:0]] <= head_op.rx_byte;
		end
	end

	// Frame position and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			pending_q       <= 1'b0;
			expected_id_q   <= '0;
			expected_data_q <= '0;
			byte_index_q    <= '0;
			data_sum_q      <= '0;
			data_lh_q       <= '0;
			error_q         <= '0;
		end else if (adv) begin
			case (head_op.func)
				FUNC_REQUEST: begin
					if (frame_last) begin
						pos_q           <= '0;
						pending_q       <= 1'b1;
						expected_id_q   <= head_op.servo_id;
						expected_data_q <= head_op.rdc;
						byte_index_q    <= '0;
						data_sum_q      <= '0;
						data_lh_q       <= '0;
						error_q         <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				FUNC_RECEIVE: begin
					if (pending_q) begin
						if (in_header) begin
							byte_index_q <= byte_index_q + 1'b1;
						end else if (in_data) begin
							byte_index_q <= byte_index_q + 1'b1;
							data_sum_q   <= data_sum_q + head_op.rx_byte;
							if (data_idx == 4'd0) begin
								data_lh_q[7:0] <= head_op.rx_byte;
							end else if (data_idx == 4'd1) begin
								data_lh_q[15:8] <= head_op.rx_byte;
							end
						end else begin
							error_q      <= err_new;
							pending_q    <= 1'b0;
							byte_index_q <= '0;
						end
					end
				end
				FUNC_ABORT: begin
					if (pending_q) begin
						pending_q    <= 1'b0;
						byte_index_q <= '0;
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

endmodule

// File: hdl/servo_bus_packet_engine.sv
// A result beat passes the front stage, the queue and the result register.
// Received-byte and abort beats go at one per cycle when the result side does
// not stall; a send request holds the back end while it sends its parameter
// count plus six frame bytes, one per cycle. Reset clears the queue, the parser
// state and the result valid flag at once; the captured reply header bytes are
// not reset. Depends on sbpe_pkg, sbpe_front, sbpe_queue and sbpe_back.
module servo_bus_packet_engine #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  sbpe_pkg::cmd_beat_t cmd_beat,
	output logic                res_valid,
	input  logic                res_stall,
	output sbpe_pkg::res_beat_t res_beat
);
	import sbpe_pkg::*;

	logic          push_valid;
	op_t           push_op;
	op_t           head_op;
	logic          pop;
	queue_status_t status;

	// Front end: accept and classify.
	sbpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_beat   (cmd_beat),
		.push_valid (push_valid),
		.push_ready (status.push_ready),
		.push_op    (push_op)
	);

	// Decoupling queue.
	sbpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.pop        (pop),
		.status     (status),
		.head_op    (head_op)
	);

	// Back end: frame transmit and reply parsing.
	sbpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.head_op   (head_op),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the servo bus packet engine: a directed table and then
// random request and reply traffic, each result beat checked against typed-in results or an in-bench model.
// Depends on sbpe_pkg and the servo_bus_packet_engine top level.
module tb_top;
	import sbpe_pkg::*;

	// Function code that the engine ignores.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam int RANDOM_ITEMS   = 360;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 160;
	localparam int PRESSURE_AT    = 80;
	localparam int QUIET_FROM     = 180;
	localparam int QUIET_SPAN     = 80;
	localparam int MAX_REPORTS    = 40;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_beat_t cmd_beat;
	logic      res_valid;
	logic      res_stall;
	res_beat_t res_beat;

	servo_bus_packet_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_beat  (cmd_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

	// Directed stimulus row: a command and, where it is obvious, its results typed in.
	typedef struct {
		cmd_beat_t   cmd;
		bit          fixed;
		int unsigned nfixed;
		res_beat_t   fixed_res;
	} dir_row_t;

	dir_row_t  dir_rows [$];
	res_beat_t expected_beats [$];
	res_beat_t predicted_now [$];
	res_beat_t want;

	int  mismatches   = 0;
	int  cycles       = 0;
	int  items_sent   = 0;
	int  beats_seen   = 0;
	int  frames_seen  = 0;
	int  replies_seen = 0;
	int  aborts_seen  = 0;
	bit  quiet        = 1'b0;
	bit  pressure_on  = 1'b0;
	bit  pressure_done = 1'b0;

	// Model state of the reply parser.
	logic        eng_pending = 1'b0;
	logic [7:0]  eng_id      = 8'h00;
	logic [2:0]  eng_ndata   = 3'd0;
	logic [3:0]  eng_index   = 4'd0;
	logic [7:0]  eng_hdr [5];
	logic [7:0]  eng_sum     = 8'h00;
	logic [15:0] eng_data    = 16'h0000;
	logic [11:0] eng_err     = 12'h000;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run limit of %0d cycles reached with %0d beats outstanding.",
				CYCLE_LIMIT, expected_beats.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0d] mismatch %0d: %s", cycles, mismatches, msg);
	endtask

	// Works out the result beats that one command beat causes and updates the model state.
	function automatic void predict_engine(input cmd_beat_t c);
		logic [2:0] pc;
		logic [2:0] rdc;
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] chk;
		logic [7:0] n;
		res_beat_t  r;
		predicted_now.delete();
		r = '0;
		case (c.func)
			FUNC_REQUEST: begin
				pc  = (c.param_count > MAX_PARAMS) ? MAX_PARAMS : c.param_count;
				rdc = (c.reply_data_count > MAX_REPLY_DATA) ? MAX_REPLY_DATA
					: c.reply_data_count;
				len = {5'd0, pc} + LEN_EXTRA;
				sum = c.servo_id + len + c.instruction;
				r.kind = KIND_TX;
				r.tx_byte = START_BYTE;
				predicted_now.push_back(r);
				predicted_now.push_back(r);
				r.tx_byte = c.servo_id;
				predicted_now.push_back(r);
				r.tx_byte = len;
				predicted_now.push_back(r);
				r.tx_byte = c.instruction;
				predicted_now.push_back(r);
				for (int i = 0; i < int'(pc); i++) begin
					r.tx_byte = (i < PARAM_SLOTS) ? c.param_bytes[8*i +: 8] : 8'h00;
					sum = sum + r.tx_byte;
					predicted_now.push_back(r);
				end
				r.tx_byte = ~sum;
				r.last = 1'b1;
				predicted_now.push_back(r);
				// A new request always replaces whatever reply was pending.
				eng_pending = 1'b1;
				eng_id      = c.servo_id;
				eng_ndata   = rdc;
				eng_index   = 4'd0;
				eng_sum     = 8'h00;
				eng_data    = 16'h0000;
				eng_err     = 12'h000;
			end
			FUNC_RECEIVE: begin
				if (eng_pending) begin
					if (eng_index < HDR_LEN) begin
						eng_hdr[eng_index] = c.rx_byte;
						eng_index = eng_index + 4'd1;
					end else if (eng_index < HDR_LEN + {1'b0, eng_ndata}) begin
						eng_sum = eng_sum + c.rx_byte;
						if (eng_index == HDR_LEN)
							eng_data[7:0] = c.rx_byte;
						else if (eng_index == HDR_LEN + 4'd1)
							eng_data[15:8] = c.rx_byte;
						eng_index = eng_index + 4'd1;
					end else begin
						// Checksum byte: check the whole reply and decode the value.
						n = {5'd0, eng_ndata};
						if (eng_hdr[0] != START_BYTE || eng_hdr[1] != START_BYTE)
							eng_err = eng_err | ERR_HEADER;
						if (eng_hdr[2] != eng_id)
							eng_err = eng_err | ERR_ID;
						if (eng_hdr[3] != n + LEN_EXTRA) begin
							n = eng_hdr[3] - LEN_EXTRA;
							eng_err = eng_err | ERR_LENGTH;
						end
						eng_err = eng_err | {4'h0, eng_hdr[4]};
						chk = eng_hdr[2] + eng_hdr[3] + eng_hdr[4] + eng_sum;
						chk = ~chk;
						if (c.rx_byte != chk)
							eng_err = eng_err | ERR_CHECKSUM;
						r.kind = KIND_REPLY;
						if (n == 8'd1)
							r.reply_value = {8'h00, eng_data[7:0]};
						else if (n == 8'd2)
							r.reply_value = eng_data;
						r.error_flags = eng_err;
						predicted_now.push_back(r);
						eng_pending = 1'b0;
						eng_index   = 4'd0;
					end
				end
			end
			FUNC_ABORT: begin
				if (eng_pending) begin
					r.kind = KIND_ABORTED;
					r.error_flags = eng_err;
					predicted_now.push_back(r);
					eng_pending = 1'b0;
					eng_index   = 4'd0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Offers one command beat, waits for it to be taken and files its expected results.
	task automatic offer_command(input cmd_beat_t b, input bit fixed,
		input int unsigned nfixed, input res_beat_t fixed_res);
		while (!quiet && $urandom_range(0, 99) < 18) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_beat  <= b;
		do
			@(posedge clk);
		while (cmd_stall);
		if (b.func == FUNC_REQUEST || (eng_pending && b.func != FUNC_SPARE))
			items_sent++;
		predict_engine(b);
		if (fixed) begin
			if (nfixed != 0)
				expected_beats.push_back(fixed_res);
		end else begin
			foreach (predicted_now[i])
				expected_beats.push_back(predicted_now[i]);
		end
	endtask

	function automatic cmd_beat_t random_beat();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[79:0];
	endfunction

	function automatic cmd_beat_t mk_cmd(input logic [1:0] func, input logic [7:0] id,
		input logic [7:0] instr, input logic [2:0] pc, input logic [47:0] params,
		input logic [2:0] rdc, input logic [7:0] rx);
		cmd_beat_t c;
		c.func             = func;
		c.servo_id         = id;
		c.instruction      = instr;
		c.param_count      = pc;
		c.param_bytes      = params;
		c.reply_data_count = rdc;
		c.rx_byte          = rx;
		return c;
	endfunction

	function automatic res_beat_t mk_res(input logic [1:0] kind, input logic [15:0] value,
		input logic [11:0] err);
		res_beat_t r;
		r = '0;
		r.kind        = kind;
		r.reply_value = value;
		r.error_flags = err;
		return r;
	endfunction

	function automatic void add_row(input cmd_beat_t c, input bit fixed,
		input int unsigned nfixed, input res_beat_t r);
		dir_row_t row;
		row.cmd       = c;
		row.fixed     = fixed;
		row.nfixed    = nfixed;
		row.fixed_res = r;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_rx(input logic [7:0] rx);
		add_row(mk_cmd(FUNC_RECEIVE, 8'h00, 8'h00, 3'd0, 48'h0, 3'd0, rx), 1'b0, 0, '0);
	endfunction

	// Bytes and aborts sent while no reply is pending, or the spare code, all ignored.
	task automatic offer_ignored();
		cmd_beat_t b;
		b = random_beat();
		if (eng_pending)
			b.func = FUNC_SPARE;
		else
			case ($urandom_range(0, 2))
				0: b.func = FUNC_RECEIVE;
				1: b.func = FUNC_ABORT;
				default: b.func = FUNC_SPARE;
			endcase
		offer_command(b, 1'b0, 0, '0);
	endtask

	// One request and its reply, mostly well formed, sometimes corrupted or cut short.
	task automatic run_transaction();
		cmd_beat_t   b;
		logic [7:0]  body [$];
		logic [7:0]  chk;
		logic [7:0]  len;
		int unsigned nd;
		int unsigned cut;
		int          ending;
		bit          bad_chk;
		b = random_beat();
		b.func = FUNC_REQUEST;
		offer_command(b, 1'b0, 0, '0);
		nd  = (b.reply_data_count > MAX_REPLY_DATA) ? int'(MAX_REPLY_DATA)
			: int'(b.reply_data_count);
		len = 8'(nd) + LEN_EXTRA;
		body.push_back(START_BYTE);
		body.push_back(START_BYTE);
		body.push_back(b.servo_id);
		body.push_back(len);
		body.push_back(($urandom_range(0, 99) < 70) ? 8'h00 : 8'($urandom()));
		for (int i = 0; i < int'(nd); i++)
			body.push_back(8'($urandom()));
		bad_chk = 1'b0;
		if ($urandom_range(0, 99) >= 60)
			case ($urandom_range(0, 4))
				0: body[$urandom_range(0, 1)] = 8'($urandom());
				1: body[2] = 8'($urandom());
				2: body[3] = 8'($urandom_range(0, 8));
				3: bad_chk = 1'b1;
				default: begin
					foreach (body[i])
						body[i] = 8'($urandom());
					bad_chk = 1'b1;
				end
			endcase
		chk = 8'h00;
		for (int i = 2; i < body.size(); i++)
			chk = chk + body[i];
		chk = ~chk;
		if (bad_chk)
			chk = chk ^ 8'($urandom_range(1, 255));
		body.push_back(chk);
		// Now and then the reply is cut short, then aborted or replaced by the next request.
		cut    = body.size();
		ending = $urandom_range(0, 99);
		if (ending < 14)
			cut = $urandom_range(0, body.size() - 1);
		for (int i = 0; i < int'(cut); i++) begin
			b = random_beat();
			b.func = FUNC_RECEIVE;
			b.rx_byte = body[i];
			offer_command(b, 1'b0, 0, '0);
		end
		if (ending < 9) begin
			b = random_beat();
			b.func = FUNC_ABORT;
			offer_command(b, 1'b0, 0, '0);
		end
	endtask

	// Result side stall: random, quiet during the calm stretch, and one long hold-off.
	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pressure_on && !pressure_done) begin
				pressure_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_stall <= !quiet && ($urandom_range(0, 99) < 18);
			end
		end
	end

	// Result checking: every accepted beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			beats_seen++;
			if (expected_beats.size() == 0) begin
				log_mismatch($sformatf("unexpected beat kind %0d tx %02h value %04h err %03h",
					res_beat.kind, res_beat.tx_byte, res_beat.reply_value,
					res_beat.error_flags));
			end else begin
				want = expected_beats.pop_front();
				if (res_beat.kind !== want.kind)
					log_mismatch($sformatf("kind %0d, expected %0d", res_beat.kind, want.kind));
				if (res_beat.tx_byte !== want.tx_byte)
					log_mismatch($sformatf("tx_byte %02h, expected %02h",
						res_beat.tx_byte, want.tx_byte));
				if (res_beat.last !== want.last)
					log_mismatch($sformatf("last %0d, expected %0d", res_beat.last, want.last));
				if (res_beat.reply_value !== want.reply_value)
					log_mismatch($sformatf("reply_value %04h, expected %04h",
						res_beat.reply_value, want.reply_value));
				if (res_beat.error_flags !== want.error_flags)
					log_mismatch($sformatf("error_flags %03h, expected %03h",
						res_beat.error_flags, want.error_flags));
				if (want.kind == KIND_TX && want.last)
					frames_seen++;
				else if (want.kind == KIND_REPLY)
					replies_seen++;
				else if (want.kind == KIND_ABORTED)
					aborts_seen++;
			end
		end
	end

	// Stimulus: reset, the directed table, the random traffic, then the drain.
	initial begin
		int target;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_beat  = '0;
		foreach (eng_hdr[i])
			eng_hdr[i] = 8'h00;

		// Ignored after reset: byte and abort with nothing pending, and the spare code.
		add_row(mk_cmd(FUNC_RECEIVE, 8'h00, 8'h00, 3'd0, 48'h0, 3'd0, 8'hFF), 1'b1, 0, '0);
		add_row(mk_cmd(FUNC_ABORT, 8'h00, 8'h00, 3'd0, 48'h0, 3'd0, 8'h00), 1'b1, 0, '0);
		add_row(mk_cmd(FUNC_SPARE, 8'hFF, 8'hFF, 3'd7, {48{1'b1}}, 3'd7, 8'hFF),
			1'b1, 0, '0);
		// Both counts above their limits, then a request that replaces the pending one.
		add_row(mk_cmd(FUNC_REQUEST, 8'hFF, 8'hFF, 3'd7, {48{1'b1}}, 3'd7, 8'h00),
			1'b0, 0, '0);
		add_row(mk_cmd(FUNC_REQUEST, 8'h01, 8'h02, 3'd0, 48'h0, 3'd0, 8'h00), 1'b0, 0, '0);
		add_row(mk_cmd(FUNC_ABORT, 8'h00, 8'h00, 3'd0, 48'h0, 3'd0, 8'h00), 1'b1, 1,
			mk_res(KIND_ABORTED, 16'h0000, 12'h000));
		// Two-byte reply with a servo error and a bad checksum.
		add_row(mk_cmd(FUNC_REQUEST, 8'h05, 8'h03, 3'd2, 48'h1234, 3'd2, 8'h00),
			1'b0, 0, '0);
		add_rx(8'hFF);
		add_rx(8'hFF);
		add_rx(8'h05);
		add_rx(8'h04);
		add_rx(8'h20);
		add_rx(8'h34);
		add_rx(8'h12);
		add_row(mk_cmd(FUNC_RECEIVE, 8'h00, 8'h00, 3'd0, 48'h0, 3'd0, 8'h00), 1'b1, 1,
			mk_res(KIND_REPLY, 16'h1234, ERR_CHECKSUM | 12'h020));
		// Bad start byte, wrong id, short length field and every servo error bit.
		add_row(mk_cmd(FUNC_REQUEST, 8'h07, 8'h10, 3'd0, 48'h0, 3'd1, 8'h00), 1'b0, 0, '0);
		add_rx(8'h00);
		add_rx(8'hFF);
		add_rx(8'h09);
		add_rx(8'h02);
		add_rx(8'hFF);
		add_rx(8'hAB);
		add_row(mk_cmd(FUNC_RECEIVE, 8'h00, 8'h00, 3'd0, 48'h0, 3'd0, 8'h4A), 1'b1, 1,
			mk_res(KIND_REPLY, 16'h0000, ERR_HEADER | ERR_ID | ERR_LENGTH | 12'h0FF));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer_command(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].nfixed,
				dir_rows[i].fixed_res);

		// Random traffic, with a calm stretch and one long result hold-off along the way.
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			quiet = (items_sent >= target - RANDOM_ITEMS + QUIET_FROM) &&
				(items_sent < target - RANDOM_ITEMS + QUIET_FROM + QUIET_SPAN);
			if (items_sent >= target - RANDOM_ITEMS + PRESSURE_AT)
				pressure_on = 1'b1;
			if ($urandom_range(0, 99) < 8)
				offer_ignored();
			else
				run_transaction();
		end
		cmd_valid <= 1'b0;
		quiet = 1'b0;

		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d directed rows and %0d active command beats in %0d cycles.",
			dir_rows.size(), items_sent, cycles);
		$display("Checked %0d result beats: %0d frames, %0d replies, %0d aborts.",
			beats_seen, frames_seen, replies_seen, aborts_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
